// ===== src/pag_pkg.sv =====
// ----------------------------------------------------------------------------
// pag_pkg
// Shared types, constants and helpers for the polygon axis grow block.
// ----------------------------------------------------------------------------
package pag_pkg;

    // Coordinate narrowing width and output coordinate width
    localparam int COORD_WIDTH = 32;
    localparam int OUT_W       = 32;
    localparam int IN_W        = 31;
    localparam int NARROW_W    = (COORD_WIDTH < OUT_W) ? COORD_WIDTH : OUT_W;

    // Edge queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic REG_SHIFT_AMOUNT = 1'b0;
    localparam logic REG_GROW_SIDE    = 1'b1;

    // Side to grow
    typedef enum logic [1:0] {
        SIDE_LEFT   = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_BOTTOM = 2'd2,
        SIDE_TOP    = 2'd3
    } side_t;

    // One classified, shifted edge
    typedef struct packed {
        logic                    start;
        logic signed [OUT_W-1:0] px;
        logic signed [OUT_W-1:0] py;
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
    } edge_t;

    // Wrap to the coordinate width, then sign-extend to the output width
    function automatic logic signed [OUT_W-1:0] narrow(input logic signed [OUT_W-1:0] v);
        logic signed [OUT_W-1:0] t;
        t = v <<< (OUT_W - NARROW_W);
        return t >>> (OUT_W - NARROW_W);
    endfunction

endpackage

// ===== src/pag_front.sv =====
// ----------------------------------------------------------------------------
// pag_front
// Holds the configuration, classifies each edge by direction and side, and
// applies the shift to the affected endpoints before queueing the item.
// ----------------------------------------------------------------------------
module pag_front
    import pag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [IN_W-1:0]       cfg_data,
    input  logic                  starts_polygon,
    input  logic signed [IN_W-1:0] prev_x,
    input  logic signed [IN_W-1:0] prev_y,
    input  logic signed [IN_W-1:0] cur_x,
    input  logic signed [IN_W-1:0] cur_y,
    output edge_t                 edge_out
);

    logic signed [OUT_W-1:0] shift_reg;
    logic signed [OUT_W-1:0] neg_shift_reg;
    side_t                   side_reg;

    logic signed [OUT_W-1:0] shift_next;
    logic signed [OUT_W-1:0] delta;
    logic signed [OUT_W-1:0] px32, py32, cx32, cy32;
    logic                    lt_x, gt_x, eq_x, lt_y, gt_y, eq_y;
    logic                    mv_prev, mv_cur;

    // Configuration writes; the negated amount is kept ready for left and bottom
    assign shift_next = {cfg_data[IN_W-1], cfg_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            neg_shift_reg <= '0;
            side_reg      <= SIDE_LEFT;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SHIFT_AMOUNT)
            begin
                shift_reg     <= shift_next;
                neg_shift_reg <= -shift_next;
            end
            else
            begin
                side_reg <= side_t'(cfg_data[1:0]);
            end
        end
    end

    // Edge direction
    assign lt_x = cur_x < prev_x;
    assign gt_x = cur_x > prev_x;
    assign eq_x = cur_x == prev_x;
    assign lt_y = cur_y < prev_y;
    assign gt_y = cur_y > prev_y;
    assign eq_y = cur_y == prev_y;

    // Which endpoints move
    always_comb
    begin
        mv_prev = 1'b0;
        mv_cur  = 1'b0;
        unique case (side_reg)
            SIDE_LEFT:
            begin
                mv_prev = lt_y || (eq_y && gt_x);
                mv_cur  = lt_y || (eq_y && lt_x);
            end
            SIDE_RIGHT:
            begin
                mv_prev = gt_y || (eq_y && lt_x);
                mv_cur  = gt_y || (eq_y && gt_x);
            end
            SIDE_BOTTOM:
            begin
                mv_prev = gt_x || (eq_x && gt_y);
                mv_cur  = gt_x || (eq_x && lt_y);
            end
            SIDE_TOP:
            begin
                mv_prev = lt_x || (eq_x && lt_y);
                mv_cur  = lt_x || (eq_x && gt_y);
            end
            default:
            begin
                mv_prev = 1'b0;
                mv_cur  = 1'b0;
            end
        endcase
    end

    // Shift along the selected axis
    assign delta = side_reg[0] ? shift_reg : neg_shift_reg;
    assign px32  = {prev_x[IN_W-1], prev_x};
    assign py32  = {prev_y[IN_W-1], prev_y};
    assign cx32  = {cur_x[IN_W-1], cur_x};
    assign cy32  = {cur_y[IN_W-1], cur_y};

    always_comb
    begin
        edge_out.start = starts_polygon;
        if (side_reg[1])
        begin
            edge_out.px = narrow(px32);
            edge_out.cx = narrow(cx32);
            edge_out.py = narrow(mv_prev ? py32 + delta : py32);
            edge_out.cy = narrow(mv_cur ? cy32 + delta : cy32);
        end
        else
        begin
            edge_out.px = narrow(mv_prev ? px32 + delta : px32);
            edge_out.cx = narrow(mv_cur ? cx32 + delta : cx32);
            edge_out.py = narrow(py32);
            edge_out.cy = narrow(cy32);
        end
    end

endmodule

// ===== src/pag_queue.sv =====
// ----------------------------------------------------------------------------
// pag_queue
// Short edge queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module pag_queue
    import pag_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  edge_t push_data,
    output logic  full,
    input  logic  pop,
    output edge_t head,
    output logic  empty
);

    edge_t             q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = q_mem_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !do_pop |=> full)
        else $error("queue lost an entry while full");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== src/pag_back.sv =====
// ----------------------------------------------------------------------------
// pag_back
// Compares shifted edges against the emission history and delivers zero,
// one or two vertices per edge through a registered output.
// ----------------------------------------------------------------------------
module pag_back
    import pag_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  edge_t                   head,
    input  logic                    empty,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] out_x,
    output logic signed [OUT_W-1:0] out_y,
    output logic                    run_last
);

    logic                    have_emitted_reg, have_emitted_next;
    logic signed [OUT_W-1:0] first_x_reg, first_x_next;
    logic signed [OUT_W-1:0] first_y_reg, first_y_next;
    logic signed [OUT_W-1:0] recent_x_reg, recent_x_next;
    logic signed [OUT_W-1:0] recent_y_reg, recent_y_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic signed [OUT_W-1:0] pend_x_reg, pend_x_next;
    logic signed [OUT_W-1:0] pend_y_reg, pend_y_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] out_x_reg, out_x_next;
    logic signed [OUT_W-1:0] out_y_reg, out_y_next;
    logic                    out_last_reg, out_last_next;

    logic                    slot_free;
    logic                    start_eff;
    logic                    emit_prev, emit_cur;
    logic signed [OUT_W-1:0] first_x_eff, first_y_eff;

    assign slot_free = !out_valid_reg || !out_stall;
    assign pop       = slot_free && !pend_valid_reg && !empty;

    // Emission decisions for the head item
    assign start_eff   = head.start || !have_emitted_reg;
    assign emit_prev   = start_eff || head.px != recent_x_reg || head.py != recent_y_reg;
    assign first_x_eff = start_eff ? head.px : first_x_reg;
    assign first_y_eff = start_eff ? head.py : first_y_reg;
    assign emit_cur    = (head.cx != first_x_eff || head.cy != first_y_eff) &&
                         (head.cx != head.px || head.cy != head.py);

    // History, pending vertex and output register
    always_comb
    begin
        have_emitted_next = have_emitted_reg;
        first_x_next      = first_x_reg;
        first_y_next      = first_y_reg;
        recent_x_next     = recent_x_reg;
        recent_y_next     = recent_y_reg;
        pend_valid_next   = pend_valid_reg;
        pend_x_next       = pend_x_reg;
        pend_y_next       = pend_y_reg;
        out_valid_next    = out_valid_reg;
        out_x_next        = out_x_reg;
        out_y_next        = out_y_reg;
        out_last_next     = out_last_reg;

        if (slot_free)
        begin
            out_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                // second vertex of a two-vertex edge
                out_valid_next  = 1'b1;
                out_x_next      = pend_x_reg;
                out_y_next      = pend_y_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (pop)
            begin
                have_emitted_next = 1'b1;
                first_x_next      = first_x_eff;
                first_y_next      = first_y_eff;
                if (emit_prev)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = head.px;
                    out_y_next     = head.py;
                    out_last_next  = !emit_cur;
                    recent_x_next  = head.px;
                    recent_y_next  = head.py;
                    if (emit_cur)
                    begin
                        pend_valid_next = 1'b1;
                        pend_x_next     = head.cx;
                        pend_y_next     = head.cy;
                    end
                end
                else if (emit_cur)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = head.cx;
                    out_y_next     = head.cy;
                    out_last_next  = 1'b1;
                end
                if (emit_cur)
                begin
                    recent_x_next = head.cx;
                    recent_y_next = head.cy;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_emitted_reg <= 1'b0;
            first_x_reg      <= '0;
            first_y_reg      <= '0;
            recent_x_reg     <= '0;
            recent_y_reg     <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            have_emitted_reg <= have_emitted_next;
            first_x_reg      <= first_x_next;
            first_y_reg      <= first_y_next;
            recent_x_reg     <= recent_x_next;
            recent_y_reg     <= recent_y_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_x_reg   <= pend_x_next;
        pend_y_reg   <= pend_y_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign run_last  = out_last_reg;

`ifndef SYNTHESIS
    a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg && !out_last_reg)
        else $error("pending vertex without a first vertex in the output");
    a_no_pop_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !pend_valid_reg)
        else $error("edge taken while a vertex is pending");
    a_history_set: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> have_emitted_reg)
        else $error("history not set after an edge");
`endif

endmodule

// ===== src/polygon_axis_grow_top.sv =====
// Polygon axis grow: accepts one polygon edge per cycle while in_stall is low
// (previous and current vertex, the wrap edge first) and emits 0 to 2 shifted
// vertices per edge with run_last marking the final vertex of each edge. The
// front classifies and shifts in the accepting cycle and feeds a 4-entry
// queue; the back delivers one vertex per cycle through its output register
// while out_stall is low, and takes no new edge from the queue while the
// second vertex of an edge is still pending. Write the
// configuration only while the block is idle.
// ----------------------------------------------------------------------------
// polygon_axis_grow_top
// Top level: front classifier, edge queue and emission back end.
// ----------------------------------------------------------------------------
module polygon_axis_grow_top
    import pag_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [IN_W-1:0]         cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    starts_polygon,
    input  logic signed [IN_W-1:0]  prev_x,
    input  logic signed [IN_W-1:0]  prev_y,
    input  logic signed [IN_W-1:0]  cur_x,
    input  logic signed [IN_W-1:0]  cur_y,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] out_x,
    output logic signed [OUT_W-1:0] out_y,
    output logic                    run_last
);

    edge_t front_edge;
    edge_t q_head;
    logic  q_full, q_empty, q_pop;

    assign in_stall = q_full;

    pag_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .starts_polygon (starts_polygon),
        .prev_x         (prev_x),
        .prev_y         (prev_y),
        .cur_x          (cur_x),
        .cur_y          (cur_y),
        .edge_out       (front_edge)
    );

    pag_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (front_edge),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    pag_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .run_last  (run_last)
    );

endmodule
